// ----- hw/rtl/bll_pkg.sv -----
// Shared constants, types and helper functions of the binary lifting ancestor engine.
// Used by the channel interfaces, the sequencer and the top level.
`default_nettype none
package bll_pkg;

  localparam int NODE_SLOTS = 65536;
  localparam int LEVELS     = 16;

  localparam int DATA_W    = 16;
  localparam int NODE_W    = $clog2(NODE_SLOTS);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ANC_AW    = NODE_W + LVL_W;
  localparam int ANC_DEPTH = NODE_SLOTS * (2 ** LVL_W);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [NODE_W-1:0] node_idx_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  typedef struct packed {
    logic              we;
    logic [ANC_AW-1:0] waddr;
    word_t             wdata;
    logic              re;
    logic [ANC_AW-1:0] raddr;
  } anc_port_t;

  typedef struct packed {
    logic      we;
    node_idx_t waddr;
    word_t     wdata;
    logic      re;
    node_idx_t raddr;
  } dep_port_t;

  typedef struct packed {
    word_t ancestor;
    logic  build_done;
  } result_t;

  function automatic logic node_ok(input word_t n);
    return 32'(n) < NODE_SLOTS;
  endfunction

  function automatic node_idx_t node_idx(input word_t n);
    logic [31:0] ext;
    ext = 32'(n);
    return ext[NODE_W-1:0];
  endfunction

  function automatic logic [ANC_AW-1:0] anc_addr(input node_idx_t idx, input lvl_t lvl);
    return {idx, lvl};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bll_in_if.sv -----
// Input channel of the ancestor engine: valid/ready with the request payload.
// Depends on bll_pkg for the word type.
`default_nettype none
interface bll_in_if;
  logic          valid;
  logic          ready;
  logic [1:0]    req_type;
  bll_pkg::word_t node_a;
  bll_pkg::word_t node_b;
  bll_pkg::word_t node_depth;

  modport source (output valid, req_type, node_a, node_b, node_depth, input ready);
  modport sink   (input valid, req_type, node_a, node_b, node_depth, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bll_out_if.sv -----
// Result channel of the ancestor engine: valid/ready with ancestor and build status.
// Depends on bll_pkg for the word type.
`default_nettype none
interface bll_out_if;
  logic           valid;
  logic           ready;
  bll_pkg::word_t ancestor;
  logic           build_done;

  modport source (output valid, ancestor, build_done, input ready);
  modport sink   (input valid, ancestor, build_done, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bll_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module bll_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/bll_ctrl.sv -----
// Request sequencer: load, level build by doubling and lifting query over the two RAMs.
// Depends on bll_pkg and bll_in_if; drives the RAM ports and hands results to the top level.
`default_nettype none
module bll_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bll_in_if.sink                    in_chan,
  input  wire bll_pkg::word_t       active_nodes,
  output      bll_pkg::anc_port_t   anc_o,
  input  wire bll_pkg::word_t       anc_rdata,
  output      bll_pkg::dep_port_t   dep_o,
  input  wire bll_pkg::word_t       dep_rdata,
  output      bll_pkg::result_t     res_o,
  output      logic                 res_valid,
  input  wire logic                 res_ready
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_B_START, S_B_R1, S_B_R2, S_B_WR,
    S_Q_DA, S_Q_DB, S_Q_DCMP, S_Q_L1, S_Q_L1W, S_Q_L1D, S_Q_EQ,
    S_Q_L2, S_Q_L2A, S_Q_L2B, S_Q_FIN, S_Q_FINW, S_DONE
  } state_t;

  localparam bll_pkg::lvl_t      LVL_TOP  = bll_pkg::LVL_W'(bll_pkg::LEVELS - 1);
  localparam bll_pkg::lvl_t      LVL_ONE  = bll_pkg::LVL_W'(1);
  localparam bll_pkg::node_idx_t NODE_ONE = bll_pkg::NODE_W'(1);
  localparam bll_pkg::node_idx_t NODE_TOP = bll_pkg::NODE_W'(bll_pkg::NODE_SLOTS - 1);

  state_t              state_r, state_nxt;
  bll_pkg::word_t      a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  bll_pkg::word_t      u_r, u_nxt, v_r, v_nxt;
  bll_pkg::word_t      du_r, du_nxt, dv_r, dv_nxt;
  bll_pkg::word_t      x_r, x_nxt, res_r, res_nxt;
  bll_pkg::lvl_t       lvl_r, lvl_nxt;
  bll_pkg::node_idx_t  ni_r, ni_nxt, last_r, last_nxt;
  logic                built_r, built_nxt;

  bll_pkg::word_t      anc_val, dep_val;
  logic                in_acc;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign res_valid     = (state_r == S_DONE);
  assign res_o         = '{ancestor: res_r, build_done: built_r};

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    du_nxt    = du_r;
    dv_nxt    = dv_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    lvl_nxt   = lvl_r;
    ni_nxt    = ni_r;
    last_nxt  = last_r;
    built_nxt = built_r;
    anc_o     = '0;
    dep_o     = '0;
    anc_val   = '0;
    dep_val   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt   = in_chan.node_a;
          b_nxt   = in_chan.node_b;
          d_nxt   = in_chan.node_depth;
          u_nxt   = bll_pkg::node_ok(in_chan.node_a) ? in_chan.node_a : '0;
          v_nxt   = bll_pkg::node_ok(in_chan.node_b) ? in_chan.node_b : '0;
          res_nxt = '0;
          if (32'(active_nodes) > bll_pkg::NODE_SLOTS - 1) begin
            last_nxt = NODE_TOP;
          end else begin
            last_nxt = bll_pkg::node_idx(active_nodes);
          end
          case (in_chan.req_type)
            bll_pkg::REQ_LOAD:  state_nxt = S_LOAD;
            bll_pkg::REQ_BUILD: state_nxt = S_B_START;
            bll_pkg::REQ_QUERY: state_nxt = S_Q_DA;
            default:            state_nxt = S_DONE;
          endcase
        end
      end

      S_LOAD: begin
        if (bll_pkg::node_ok(a_r) && (a_r != '0)) begin
          anc_o.we    = 1'b1;
          anc_o.waddr = bll_pkg::anc_addr(bll_pkg::node_idx(a_r), '0);
          anc_o.wdata = bll_pkg::node_ok(b_r) ? b_r : '0;
          dep_o.we    = 1'b1;
          dep_o.waddr = bll_pkg::node_idx(a_r);
          dep_o.wdata = d_r;
        end
        built_nxt = 1'b0;
        state_nxt = S_DONE;
      end

      S_B_START: begin
        if (last_r == '0) begin
          built_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          lvl_nxt   = LVL_ONE;
          ni_nxt    = NODE_ONE;
          state_nxt = S_B_R1;
        end
      end

      S_B_R1: begin
        anc_o.re    = 1'b1;
        anc_o.raddr = bll_pkg::anc_addr(ni_r, lvl_r - LVL_ONE);
        state_nxt   = S_B_R2;
      end

      S_B_R2: begin
        x_nxt       = anc_rdata;
        anc_o.re    = 1'b1;
        anc_o.raddr = bll_pkg::anc_addr(bll_pkg::node_idx(anc_rdata), lvl_r - LVL_ONE);
        state_nxt   = S_B_WR;
      end

      S_B_WR: begin
        anc_val     = (x_r == '0) ? '0 : anc_rdata;
        anc_o.we    = 1'b1;
        anc_o.waddr = bll_pkg::anc_addr(ni_r, lvl_r);
        anc_o.wdata = anc_val;
        if (ni_r == last_r) begin
          if (lvl_r == LVL_TOP) begin
            built_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            lvl_nxt   = lvl_r + LVL_ONE;
            ni_nxt    = NODE_ONE;
            state_nxt = S_B_R1;
          end
        end else begin
          ni_nxt    = ni_r + NODE_ONE;
          state_nxt = S_B_R1;
        end
      end

      S_Q_DA: begin
        dep_o.re    = 1'b1;
        dep_o.raddr = bll_pkg::node_idx(u_r);
        state_nxt   = S_Q_DB;
      end

      S_Q_DB: begin
        du_nxt      = (u_r == '0) ? '0 : dep_rdata;
        dep_o.re    = 1'b1;
        dep_o.raddr = bll_pkg::node_idx(v_r);
        state_nxt   = S_Q_DCMP;
      end

      S_Q_DCMP: begin
        dep_val = (v_r == '0) ? '0 : dep_rdata;
        if (du_r < dep_val) begin
          u_nxt  = v_r;
          v_nxt  = u_r;
          du_nxt = dep_val;
          dv_nxt = du_r;
        end else begin
          dv_nxt = dep_val;
        end
        lvl_nxt   = LVL_TOP;
        state_nxt = S_Q_L1;
      end

      S_Q_L1: begin
        if (32'(du_r) >= 32'(dv_r) + (32'd1 << lvl_r)) begin
          anc_o.re    = 1'b1;
          anc_o.raddr = bll_pkg::anc_addr(bll_pkg::node_idx(u_r), lvl_r);
          state_nxt   = S_Q_L1W;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_EQ;
        end else begin
          lvl_nxt = lvl_r - LVL_ONE;
        end
      end

      S_Q_L1W: begin
        anc_val     = (u_r == '0) ? '0 : anc_rdata;
        u_nxt       = anc_val;
        dep_o.re    = 1'b1;
        dep_o.raddr = bll_pkg::node_idx(anc_val);
        state_nxt   = S_Q_L1D;
      end

      S_Q_L1D: begin
        du_nxt = (u_r == '0) ? '0 : dep_rdata;
        if (lvl_r == '0) begin
          state_nxt = S_Q_EQ;
        end else begin
          lvl_nxt   = lvl_r - LVL_ONE;
          state_nxt = S_Q_L1;
        end
      end

      S_Q_EQ: begin
        if (u_r == v_r) begin
          res_nxt   = u_r;
          state_nxt = S_DONE;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_Q_L2;
        end
      end

      S_Q_L2: begin
        anc_o.re    = 1'b1;
        anc_o.raddr = bll_pkg::anc_addr(bll_pkg::node_idx(u_r), lvl_r);
        state_nxt   = S_Q_L2A;
      end

      S_Q_L2A: begin
        x_nxt       = (u_r == '0) ? '0 : anc_rdata;
        anc_o.re    = 1'b1;
        anc_o.raddr = bll_pkg::anc_addr(bll_pkg::node_idx(v_r), lvl_r);
        state_nxt   = S_Q_L2B;
      end

      S_Q_L2B: begin
        anc_val = (v_r == '0) ? '0 : anc_rdata;
        if ((x_r != '0) && (anc_val != '0) && (x_r != anc_val)) begin
          u_nxt = x_r;
          v_nxt = anc_val;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_FIN;
        end else begin
          lvl_nxt   = lvl_r - LVL_ONE;
          state_nxt = S_Q_L2;
        end
      end

      S_Q_FIN: begin
        anc_o.re    = 1'b1;
        anc_o.raddr = bll_pkg::anc_addr(bll_pkg::node_idx(u_r), '0);
        state_nxt   = S_Q_FINW;
      end

      S_Q_FINW: begin
        res_nxt   = (u_r == '0) ? '0 : anc_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    du_r   <= du_nxt;
    dv_r   <= dv_nxt;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    lvl_r  <= lvl_nxt;
    ni_r   <= ni_nxt;
    last_r <= last_nxt;
  end

`ifndef SYNTHESIS
  a_anc_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(anc_o.we && anc_o.re))
    else $error("ancestor RAM read and write in the same cycle");

  a_anc_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
    anc_o.we |-> (anc_o.waddr[bll_pkg::ANC_AW-1:bll_pkg::LVL_W] != '0))
    else $error("write to the sentinel row");

  a_load_clears_built: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> !built_r)
    else $error("load left build flag set");

  a_handoff_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (state_r == S_IDLE))
    else $error("result taken but sequencer not idle");

  a_build_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_B_R1) |-> ((lvl_r != '0) && (ni_r != '0) && (ni_r <= last_r)))
    else $error("build counters out of range");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/binary_lifting_lca_core.sv -----
// Top level of the binary lifting ancestor engine: config register, RAMs, sequencer, result register.
// Depends on bll_pkg, bll_in_if, bll_out_if, bll_ram and bll_ctrl.
//
// One item at a time; input ready is high only while the sequencer is idle, and a finished
// result waits in the output register while the next item is accepted. Every step is bounded
// by the single read port of the ancestor RAM (NODE_SLOTS x 2^clog2(LEVELS) words) and of the
// depth RAM, both with registered read data. A load writes the parent and depth of one valid
// nonzero node. A build visits every level from 1 to LEVELS-1 and, in each, every node from 1
// to min(active_nodes, NODE_SLOTS-1), with two dependent reads and a write per node and level.
// A query reads both depths, lifts the deeper node level by level while matching depths, and
// if the nodes have not met, lifts both jointly from the top level down and reads the parent.
// No clearing pass runs after reset: the sentinel node reads as zero by logic, and other
// entries are valid once loaded or built.
`default_nettype none
module binary_lifting_lca_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  bll_in_if.sink              in_chan,
  bll_out_if.source           out_chan,
  input  wire logic           cfg_we,
  input  wire bll_pkg::word_t cfg_wdata
);

  bll_pkg::word_t     active_r;
  bll_pkg::anc_port_t anc_port;
  bll_pkg::dep_port_t dep_port;
  bll_pkg::word_t     anc_rdata, dep_rdata;
  bll_pkg::result_t   res, out_res_r;
  logic               res_valid, res_ready, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= bll_pkg::DATA_W'(1);
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  bll_ram #(
    .DEPTH (bll_pkg::ANC_DEPTH),
    .WIDTH (bll_pkg::DATA_W)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_port.we),
    .waddr (anc_port.waddr),
    .wdata (anc_port.wdata),
    .re    (anc_port.re),
    .raddr (anc_port.raddr),
    .rdata (anc_rdata)
  );

  bll_ram #(
    .DEPTH (bll_pkg::NODE_SLOTS),
    .WIDTH (bll_pkg::DATA_W)
  ) u_dep_ram (
    .clk   (clk),
    .we    (dep_port.we),
    .waddr (dep_port.waddr),
    .wdata (dep_port.wdata),
    .re    (dep_port.re),
    .raddr (dep_port.raddr),
    .rdata (dep_rdata)
  );

  bll_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .active_nodes (active_r),
    .anc_o        (anc_port),
    .anc_rdata    (anc_rdata),
    .dep_o        (dep_port),
    .dep_rdata    (dep_rdata),
    .res_o        (res),
    .res_valid    (res_valid),
    .res_ready    (res_ready)
  );

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ancestor   = out_res_r.ancestor;
  assign out_chan.build_done = out_res_r.build_done;

endmodule
`default_nettype wire
